/* rtl/bankers_safety_check_unit_macros.svh */
// Assertion macros shared by the safety check RTL.
`ifndef BANKERS_SAFETY_CHECK_UNIT_MACROS_SVH
`define BANKERS_SAFETY_CHECK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsc: same-cycle check failed");
`define BSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsc: next-cycle check failed");
`else
`define BSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/bsc_pkg.sv */
// Package: widths, defaults and codes for the safety check unit.
package bsc_pkg;

  localparam int unsigned PROC_MAX_DEF   = 16;
  localparam int unsigned RES_MAX_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CELL  = 2'd0,
    CMD_AVAIL = 2'd1,
    CMD_RUN   = 2'd2
  } command_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NPROC = 2'd0,
    CFG_NRES  = 2'd1
  } cfg_reg_e;

endpackage

/* rtl/bsc_cell_mem.sv */
// Claim/allocation cell memory with per-cell valid bits and registered read.
module bsc_cell_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_claim_i,
  input  logic [DW-1:0] wr_held_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_claim_o,
  output logic [DW-1:0] rd_held_o
);

  logic [2*DW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [2*DW-1:0] rd_q;
  logic            rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_claim_i, wr_held_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // never-written cells read as zero
  assign rd_claim_o = rd_vld_q ? rd_q[2*DW-1:DW] : '0;
  assign rd_held_o  = rd_vld_q ? rd_q[DW-1:0]    : '0;

endmodule

/* rtl/bankers_safety_check_unit.sv */
// Banker's algorithm safety check: table loads, iterative check, order output.
//
// Input channel (in_valid_i/in_ready_o) carries load and run commands. A cell
// load writes claim and allocation for one process/resource, an available load
// writes one free count; neither gives a result. A run copies the free counts
// into the working vector and then walks the processes pass by pass with one
// shared compare/add unit on the working vector. Each resource of a process
// takes two steps (memory read, then compare or add), and a run makes up to
// as many passes as there are processes. The input is not ready during a run.
// Output channel (out_valid_o/out_ready_i) delivers the safe order, one
// transfer per process with last_o on the final one, or a single transfer with
// is_safe_o low. A one-entry output register holds a result while the receiver
// stalls; the sequencer waits on it. Configuration writes (cfg_*) are always
// taken. Reset clears the cell table through valid bits and the free counts
// directly, so there is no clearing pass and the block is ready in the first
// cycle after reset.
`include "bankers_safety_check_unit_macros.svh"

module bankers_safety_check_unit #(
  parameter int unsigned PROC_MAX   = bsc_pkg::PROC_MAX_DEF,
  parameter int unsigned RES_MAX    = bsc_pkg::RES_MAX_DEF,
  parameter int unsigned COUNT_BITS = bsc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bsc_pkg::CMD_W-1:0]     command_i,
  input  logic [bsc_pkg::IDX_W-1:0]     process_index_i,
  input  logic [bsc_pkg::IDX_W-1:0]     resource_index_i,
  input  logic [bsc_pkg::VAL_W-1:0]     max_claim_i,
  input  logic [bsc_pkg::VAL_W-1:0]     allocated_i,
  input  logic [bsc_pkg::VAL_W-1:0]     available_units_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bsc_pkg::IDX_W-1:0]     process_id_o,
  output logic                          is_safe_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bsc_pkg::CFG_W-1:0]     cfg_data_i
);
  import bsc_pkg::*;

  localparam int unsigned PW    = (PROC_MAX > 1) ? $clog2(PROC_MAX) : 1;
  localparam int unsigned RW    = (RES_MAX > 1) ? $clog2(RES_MAX) : 1;
  localparam int unsigned NPW   = $clog2(PROC_MAX + 1);
  localparam int unsigned NRW   = $clog2(RES_MAX + 1);
  localparam int unsigned DEPTH = PROC_MAX * RES_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW    = COUNT_BITS + $clog2(PROC_MAX + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROC = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_ARD  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_NEXT = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [PW-1:0]   p_q, p_d;
  logic [RW-1:0]   r_q, r_d;
  logic [NPW-1:0]  np_q, np_d;
  logic [NRW-1:0]  nr_q, nr_d;
  logic [NPW-1:0]  cnt_q, cnt_d;
  logic [PW-1:0]   k_q, k_d;
  logic            granted_q, granted_d;
  logic            safe_q, safe_d;
  logic [CFG_W-1:0] nproc_q, nres_q;

  logic [PROC_MAX-1:0]   done_q;
  logic [PW-1:0]         order_q [PROC_MAX];
  logic [COUNT_BITS-1:0] free_q  [RES_MAX];
  logic [WW-1:0]         work_q  [RES_MAX];

  logic             out_valid_q;
  logic [IDX_W-1:0] out_pid_q;
  logic             out_safe_q;
  logic             out_last_q;

  logic                  run_start, mem_we, free_we, work_add, grant, out_load;
  logic                  cell_ok, res_ok;
  logic                  r_last, p_last, emit_last;
  logic [NPW-1:0]        np_clamp;
  logic [NRW-1:0]        nr_clamp;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [COUNT_BITS-1:0] rd_claim, rd_held, need;
  logic [WW-1:0]         need_ext;

  bsc_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_cells (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (mem_we),
    .wr_addr_i  (wr_addr),
    .wr_claim_i (COUNT_BITS'(max_claim_i)),
    .wr_held_i  (COUNT_BITS'(allocated_i)),
    .rd_addr_i  (rd_addr),
    .rd_claim_o (rd_claim),
    .rd_held_o  (rd_held)
  );

  assign cell_ok = (int'(process_index_i) < PROC_MAX) && (int'(resource_index_i) < RES_MAX);
  assign res_ok  = (int'(resource_index_i) < RES_MAX);
  assign wr_addr = AW'(int'(process_index_i) * RES_MAX + int'(resource_index_i));
  assign rd_addr = AW'(int'(p_q) * RES_MAX + int'(r_q));

  assign np_clamp = (nproc_q == '0) ? NPW'(1) :
                    (int'(nproc_q) > PROC_MAX) ? NPW'(PROC_MAX) : NPW'(nproc_q);
  assign nr_clamp = (nres_q == '0) ? NRW'(1) :
                    (int'(nres_q) > RES_MAX) ? NRW'(RES_MAX) : NRW'(nres_q);

  assign need     = (rd_claim > rd_held) ? rd_claim - rd_held : '0;
  assign need_ext = WW'(need);

  assign r_last    = (r_q == RW'(nr_q - NRW'(1)));
  assign p_last    = (p_q == PW'(np_q - NPW'(1)));
  assign emit_last = !safe_q || (k_q == PW'(np_q - NPW'(1)));

  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    r_d       = r_q;
    np_d      = np_q;
    nr_d      = nr_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    granted_d = granted_q;
    safe_d    = safe_q;
    run_start = 1'b0;
    mem_we    = 1'b0;
    free_we   = 1'b0;
    work_add  = 1'b0;
    grant     = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (command_e'(command_i))
            CMD_CELL:  mem_we  = cell_ok;
            CMD_AVAIL: free_we = res_ok;
            CMD_RUN: begin
              run_start = 1'b1;
              np_d      = np_clamp;
              nr_d      = nr_clamp;
              cnt_d     = '0;
              p_d       = '0;
              granted_d = 1'b0;
              state_d   = S_PROC;
            end
            default: ;
          endcase
        end
      end
      S_PROC: begin
        if (done_q[p_q]) begin
          state_d = S_NEXT;
        end else begin
          r_d     = '0;
          state_d = S_CRD;
        end
      end
      S_CRD: state_d = S_CMP;
      S_CMP: begin
        if (need_ext > work_q[r_q]) begin
          state_d = S_NEXT;
        end else if (r_last) begin
          r_d     = '0;
          state_d = S_ARD;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_ARD: state_d = S_ADD;
      S_ADD: begin
        work_add = 1'b1;
        if (r_last) begin
          grant     = 1'b1;
          cnt_d     = cnt_q + 1'b1;
          granted_d = 1'b1;
          state_d   = S_NEXT;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_ARD;
        end
      end
      S_NEXT: begin
        if (p_last) begin
          // end of a pass
          if (cnt_q == np_q) begin
            safe_d  = 1'b1;
            k_d     = '0;
            state_d = S_EMIT;
          end else if (!granted_q) begin
            safe_d  = 1'b0;
            k_d     = '0;
            state_d = S_EMIT;
          end else begin
            p_d       = '0;
            granted_d = 1'b0;
            state_d   = S_PROC;
          end
        end else begin
          p_d     = p_q + 1'b1;
          state_d = S_PROC;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_q         <= '0;
      r_q         <= '0;
      np_q        <= NPW'(1);
      nr_q        <= NRW'(1);
      cnt_q       <= '0;
      k_q         <= '0;
      granted_q   <= 1'b0;
      safe_q      <= 1'b0;
      nproc_q     <= CFG_W'(1);
      nres_q      <= CFG_W'(1);
      done_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RES_MAX; i++) begin
        free_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      r_q       <= r_d;
      np_q      <= np_d;
      nr_q      <= nr_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      granted_q <= granted_d;
      safe_q    <= safe_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_NPROC: nproc_q <= cfg_data_i;
          CFG_NRES:  nres_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (free_we) begin
        free_q[RW'(resource_index_i)] <= COUNT_BITS'(available_units_i);
      end
      if (run_start) begin
        done_q <= '0;
      end else if (grant) begin
        done_q[p_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_start) begin
      for (int i = 0; i < RES_MAX; i++) begin
        work_q[i] <= WW'(free_q[i]);
      end
    end else if (work_add) begin
      work_q[r_q] <= work_q[r_q] + WW'(rd_held);
    end
    if (grant) begin
      order_q[cnt_q[PW-1:0]] <= p_q;
    end
    if (out_load) begin
      out_pid_q  <= safe_q ? IDX_W'(order_q[k_q]) : '0;
      out_safe_q <= safe_q;
      out_last_q <= emit_last;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign process_id_o = out_pid_q;
  assign is_safe_o    = out_safe_q;
  assign last_o       = out_last_q;

  `BSC_ASSERT_IMP(a_unsafe_single, clk_i, rst_ni, out_valid_o && !is_safe_o, last_o && (process_id_o == '0))
  `BSC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, state_q != S_IDLE, cnt_q <= np_q)
  `BSC_ASSERT_IMP(a_grant_fresh, clk_i, rst_ni, grant, !done_q[p_q])
  `BSC_ASSERT_NXT(a_run_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (command_i == CMD_RUN), !in_ready_o)

endmodule
